// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL, included by sorted_timer_queue.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a property on the same edge.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Check that a condition implies a property on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/stq_pkg.sv =====
// Package of types, constants and time helpers for the sorted timer queue.
`timescale 1ns / 1ps
package stq_pkg;
    localparam int TIMER_SLOTS_DEF = 32;
    localparam int MAX_FIRES_DEF   = 63;
    localparam logic [19:0] USEC_MAX     = 20'd999999;
    localparam logic [20:0] USEC_PER_SEC = 21'd1000000;

    localparam logic [2:0] FUNC_ADD      = 3'd0;
    localparam logic [2:0] FUNC_DEL_ID   = 3'd1;
    localparam logic [2:0] FUNC_DEL_SVC  = 3'd2;
    localparam logic [2:0] FUNC_CHECK    = 3'd3;
    localparam logic [2:0] FUNC_CLEAR    = 3'd4;
    localparam logic [2:0] FUNC_RST_MAX  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [31:0] exp_sec;
        logic [19:0] exp_usec;
        logic [31:0] per_sec;
        logic [19:0] per_usec;
        logic [15:0] owner;
        logic [31:0] id;
    } entry_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [31:0] tid;
        logic [15:0] svc;
        logic [31:0] dsec;
        logic [19:0] dusec;
        logic        armed;
        logic [31:0] msec;
        logic [19:0] musec;
        logic        last;
    } result_t;

    function automatic logic [19:0] sat_usec(input logic [19:0] v);
        sat_usec = (v > USEC_MAX) ? USEC_MAX : v;
    endfunction

    function automatic logic time_le(input logic [31:0] as, input logic [19:0] au,
                                     input logic [31:0] bs, input logic [19:0] bu);
        time_le = (as < bs) || ((as == bs) && (au <= bu));
    endfunction
endpackage

// ===== hw/rtl/stq_time_unit.sv =====
// Shared time adder/subtractor: a + b or a - b over seconds plus microseconds.
`timescale 1ns / 1ps
module stq_time_unit (
    input  logic        sub,
    input  logic [31:0] a_sec,
    input  logic [19:0] a_usec,
    input  logic [31:0] b_sec,
    input  logic [19:0] b_usec,
    output logic [31:0] r_sec,
    output logic [19:0] r_usec
);
    import stq_pkg::*;
    logic [20:0] us_sum;
    logic [20:0] us_dif;
    always_comb begin
        us_sum = {1'b0, a_usec} + {1'b0, b_usec};
        us_dif = {1'b0, a_usec} - {1'b0, b_usec};
        if (sub) begin
            if (a_usec >= b_usec) begin
                r_usec = us_dif[19:0];
                r_sec  = a_sec - b_sec;
            end else begin
                r_usec = 20'(us_dif + USEC_PER_SEC);
                r_sec  = a_sec - b_sec - 32'd1;
            end
        end else begin
            if (us_sum >= USEC_PER_SEC) begin
                r_usec = 20'(us_sum - USEC_PER_SEC);
                r_sec  = a_sec + b_sec + 32'd1;
            end else begin
                r_usec = us_sum[19:0];
                r_sec  = a_sec + b_sec;
            end
        end
    end
endmodule

// ===== hw/rtl/sorted_timer_queue.sv =====
// Flow: a word passes the op state, the fire check and the reply; an add also scans for
// its place and shifts the entries behind it, a delete scans to the match and shifts the
// rest down (a service purge rescans after each one), and each expiry shifts the table
// down, plus a scan and shift for a periodic reload; output stalls hold the wait states.
// One item at a time; s_axis_tready is low while an item is in work.
// Reset (synchronous, aresetn low): table empty, next id one, lateness zero.
`timescale 1ns / 1ps
module sorted_timer_queue #(
    parameter int TIMER_SLOTS        = stq_pkg::TIMER_SLOTS_DEF,
    parameter int MAX_FIRES_PER_ITEM = stq_pkg::MAX_FIRES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] func, [34:3] now_sec, [54:35] now_usec, [86:55] start_interval_sec,
    // [106:87] start_interval_usec, [138:107] period_sec, [158:139] period_usec,
    // [174:159] service_id, [206:175] timer_id, [207] zero
    input  logic [207:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] status, [33:2] result_timer_id, [49:34] result_service_id,
    // [81:50] next_delay_sec, [101:82] next_delay_usec, [102] armed,
    // [134:103] max_delay_sec, [154:135] max_delay_usec, [159:155] zero
    output logic [159:0] m_axis_tdata,
    // [0] kind
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);
    import stq_pkg::*;
    localparam int IW = $clog2(TIMER_SLOTS);
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int FW = $clog2(MAX_FIRES_PER_ITEM + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_OP = 4'd1, S_SCAN = 4'd2, S_SHIFT = 4'd3,
        S_FCHK = 4'd4, S_FIRE = 4'd5, S_EMIT = 4'd6, S_WAIT = 4'd7, S_REPLY = 4'd8,
        S_RWAIT = 4'd9, S_REL = 4'd10;

    // shift modes
    localparam logic [1:0] M_INS = 2'd0, M_DEL = 2'd1;

    entry_t        mem [TIMER_SLOTS];
    logic [3:0]    state_reg;
    logic [CW-1:0] count_reg;
    logic [31:0]   next_id_reg;
    logic [31:0]   wl_sec_reg;
    logic [19:0]   wl_usec_reg;
    logic [2:0]    func_reg;
    logic [31:0]   now_sec_reg, iv_sec_reg, pr_sec_reg, tid_reg;
    logic [19:0]   now_usec_reg, iv_usec_reg, pr_usec_reg;
    logic [15:0]   svc_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] pos_reg;
    logic [1:0]    mode_reg;
    logic          after_reg;      // shift is part of an expiry; go on to reload or emit after it
    entry_t        new_reg;
    entry_t        head_reg;
    logic [FW-1:0] fires_reg;
    logic [1:0]    status_reg;
    logic [31:0]   rid_reg;
    result_t       res_reg;
    logic          mvalid_reg;

    // shared time unit
    logic          tu_sub;
    logic [31:0]   tu_as, tu_bs, tu_rs;
    logic [19:0]   tu_au, tu_bu, tu_ru;
    stq_time_unit u_tu (
        .sub(tu_sub), .a_sec(tu_as), .a_usec(tu_au), .b_sec(tu_bs), .b_usec(tu_bu),
        .r_sec(tu_rs), .r_usec(tu_ru)
    );

    entry_t        rd_cur;
    logic [IW-1:0] ia;
    assign ia     = idx_reg[IW-1:0];
    assign rd_cur = mem[ia];

    always_comb begin
        tu_sub = 1'b0;
        tu_as  = now_sec_reg; tu_au = now_usec_reg;
        tu_bs  = iv_sec_reg;  tu_bu = iv_usec_reg;
        unique case (state_reg)
            S_FIRE: begin
                tu_sub = 1'b1;
                tu_bs  = head_reg.exp_sec; tu_bu = head_reg.exp_usec;
            end
            S_REL: begin
                tu_as = head_reg.exp_sec; tu_au = head_reg.exp_usec;
                tu_bs = head_reg.per_sec; tu_bu = head_reg.per_usec;
            end
            S_REPLY: begin
                tu_sub = 1'b1;
                tu_as  = mem[0].exp_sec; tu_au = mem[0].exp_usec;
                tu_bs  = now_sec_reg;    tu_bu = now_usec_reg;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {5'd0, res_reg.musec, res_reg.msec, res_reg.armed,
                            res_reg.dusec, res_reg.dsec, res_reg.svc, res_reg.tid,
                            res_reg.status};

    logic head_due;
    assign head_due = (count_reg != '0) &&
        time_le(mem[0].exp_sec, mem[0].exp_usec, now_sec_reg, now_usec_reg);

    logic [CW-1:0] cnt_m1;
    assign cnt_m1 = count_reg - CW'(1);

    // table writes: one entry per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == S_SHIFT) begin
            if (mode_reg == M_INS) begin
                if (idx_reg == pos_reg) mem[ia] <= new_reg;
                else mem[ia] <= mem[IW'(idx_reg - CW'(1))];
            end else if (idx_reg < cnt_m1) begin
                mem[ia] <= mem[IW'(idx_reg + CW'(1))];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            next_id_reg <= 32'd1;
            wl_sec_reg  <= '0;
            wl_usec_reg <= '0;
            mvalid_reg  <= 1'b0;
            after_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_axis_tvalid) begin
                    func_reg     <= s_axis_tdata[2:0];
                    now_sec_reg  <= s_axis_tdata[34:3];
                    now_usec_reg <= sat_usec(s_axis_tdata[54:35]);
                    iv_sec_reg   <= s_axis_tdata[86:55];
                    iv_usec_reg  <= sat_usec(s_axis_tdata[106:87]);
                    pr_sec_reg   <= s_axis_tdata[138:107];
                    pr_usec_reg  <= sat_usec(s_axis_tdata[158:139]);
                    svc_reg      <= s_axis_tdata[174:159];
                    tid_reg      <= s_axis_tdata[206:175];
                    status_reg   <= ST_OK;
                    rid_reg      <= '0;
                    fires_reg    <= '0;
                    idx_reg      <= '0;
                    state_reg    <= S_OP;
                end
                S_OP: begin
                    case (func_reg)
                        FUNC_ADD: begin
                            if (count_reg == CW'(TIMER_SLOTS)) begin
                                status_reg <= ST_FULL;
                                state_reg  <= S_FCHK;
                            end else begin
                                rid_reg     <= (next_id_reg == '0) ? 32'd1 : next_id_reg;
                                next_id_reg <= ((next_id_reg == '0) ? 32'd1 : next_id_reg)
                                               + 32'd1;
                                new_reg <= '{exp_sec: tu_rs, exp_usec: tu_ru,
                                    per_sec: pr_sec_reg, per_usec: pr_usec_reg,
                                    owner: svc_reg,
                                    id: (next_id_reg == '0) ? 32'd1 : next_id_reg};
                                idx_reg   <= '0;
                                after_reg <= 1'b0;
                                state_reg <= S_SCAN;
                            end
                        end
                        FUNC_DEL_ID, FUNC_DEL_SVC: begin
                            if (func_reg == FUNC_DEL_ID) status_reg <= ST_INVALID;
                            state_reg <= S_SCAN;
                        end
                        FUNC_CLEAR: begin
                            count_reg <= '0;
                            state_reg <= S_FCHK;
                        end
                        FUNC_RST_MAX: begin
                            wl_sec_reg  <= '0;
                            wl_usec_reg <= '0;
                            state_reg   <= S_FCHK;
                        end
                        default: state_reg <= S_FCHK;
                    endcase
                end
                S_SCAN: begin
                    // walk one entry per cycle
                    if (func_reg == FUNC_ADD || after_reg) begin
                        if (idx_reg < count_reg &&
                            time_le(rd_cur.exp_sec, rd_cur.exp_usec,
                                    new_reg.exp_sec, new_reg.exp_usec)) begin
                            idx_reg <= idx_reg + CW'(1);
                        end else begin
                            pos_reg   <= idx_reg;
                            idx_reg   <= count_reg;
                            mode_reg  <= M_INS;
                            state_reg <= S_SHIFT;
                        end
                    end else if (idx_reg >= count_reg) begin
                        state_reg <= S_FCHK;
                    end else if ((func_reg == FUNC_DEL_ID && rd_cur.id == tid_reg) ||
                                 (func_reg == FUNC_DEL_SVC && rd_cur.owner == svc_reg))
                    begin
                        if (func_reg == FUNC_DEL_ID) status_reg <= ST_OK;
                        pos_reg   <= idx_reg;
                        mode_reg  <= M_DEL;
                        state_reg <= S_SHIFT;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_SHIFT: begin
                    if (mode_reg == M_INS) begin
                        if (idx_reg == pos_reg) begin
                            count_reg <= count_reg + CW'(1);
                            after_reg <= 1'b0;
                            state_reg <= after_reg ? S_EMIT : S_FCHK;
                        end else begin
                            idx_reg <= idx_reg - CW'(1);
                        end
                    end else begin
                        if (idx_reg >= cnt_m1) begin
                            count_reg <= cnt_m1;
                            if (after_reg) begin
                                state_reg <= S_REL;
                            end else if (func_reg == FUNC_DEL_SVC) begin
                                idx_reg   <= pos_reg;
                                state_reg <= S_SCAN;
                            end else begin
                                state_reg <= S_FCHK;
                            end
                        end else begin
                            idx_reg <= idx_reg + CW'(1);
                        end
                    end
                end
                S_FCHK: begin
                    if (head_due && fires_reg != FW'(MAX_FIRES_PER_ITEM)) begin
                        head_reg  <= mem[0];
                        state_reg <= S_FIRE;
                    end else begin
                        state_reg <= S_REPLY;
                    end
                end
                S_FIRE: begin
                    if (tu_rs > wl_sec_reg || (tu_rs == wl_sec_reg && tu_ru > wl_usec_reg))
                    begin
                        wl_sec_reg  <= tu_rs;
                        wl_usec_reg <= tu_ru;
                    end
                    idx_reg   <= '0;
                    pos_reg   <= '0;
                    mode_reg  <= M_DEL;
                    after_reg <= 1'b1;
                    state_reg <= S_SHIFT;
                end
                S_REL: begin
                    if (head_reg.per_sec != '0 || head_reg.per_usec != '0) begin
                        new_reg   <= '{exp_sec: tu_rs, exp_usec: tu_ru,
                            per_sec: head_reg.per_sec, per_usec: head_reg.per_usec,
                            owner: head_reg.owner, id: head_reg.id};
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end else begin
                        after_reg <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    res_reg <= '{kind: 1'b1, status: ST_OK, tid: head_reg.id,
                        svc: head_reg.owner, dsec: '0, dusec: '0,
                        armed: (count_reg != '0), msec: wl_sec_reg, musec: wl_usec_reg,
                        last: 1'b0};
                    mvalid_reg <= 1'b1;
                    fires_reg  <= fires_reg + FW'(1);
                    state_reg  <= S_WAIT;
                end
                S_WAIT: if (m_axis_tready) begin
                    mvalid_reg <= 1'b0;
                    state_reg  <= S_FCHK;
                end
                S_REPLY: begin
                    res_reg <= '{kind: 1'b0, status: status_reg, tid: rid_reg,
                        svc: '0, dsec: (count_reg != '0 && !head_due) ? tu_rs : '0,
                        dusec: (count_reg != '0 && !head_due) ? tu_ru : '0,
                        armed: (count_reg != '0), msec: wl_sec_reg, musec: wl_usec_reg,
                        last: 1'b1};
                    mvalid_reg <= 1'b1;
                    state_reg  <= S_RWAIT;
                end
                S_RWAIT: if (m_axis_tready) begin
                    mvalid_reg <= 1'b0;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_cnt_max, aclk, aresetn, 1'b1, count_reg <= CW'(TIMER_SLOTS))
    `ASSERT_IMPL(a_no_ready_busy, aclk, aresetn, mvalid_reg, !s_axis_tready)
    `ASSERT_NEXT(a_reply_idle, aclk, aresetn,
                 mvalid_reg && m_axis_tready && res_reg.last, s_axis_tready)
endmodule

// ===== dv/sorted_timer_queue_test.sv =====
// Self-checking testbench for the sorted timer queue: directed and random operations.
`timescale 1ns / 1ps
module sorted_timer_queue_test;
    import stq_pkg::*;

    localparam int SLOTS    = 32;
    localparam int FIRE_CAP = 63;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] now_s;
        logic [19:0] now_u;
        logic [31:0] iv_s;
        logic [19:0] iv_u;
        logic [31:0] pr_s;
        logic [19:0] pr_u;
        logic [15:0] svc;
        logic [31:0] tid;
        bit          drain;
    } timer_op_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    timer_op_t op_q[$];
    timer_op_t cur_op;
    result_t   expect_q[$];
    int        mismatches;
    int        ops_sent;
    bit        word_taken;

    // timer table model
    entry_t      tbl[SLOTS];
    int          n_timers;
    logic [31:0] id_next;
    logic [31:0] late_s;
    logic [19:0] late_u;

    sorted_timer_queue i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic logic [19:0] clamp_usec(input logic [19:0] v);
        return (v > 20'd999999) ? 20'd999999 : v;
    endfunction

    function automatic bit not_later(input logic [31:0] as, input logic [19:0] au,
                                     input logic [31:0] bs, input logic [19:0] bu);
        return (as < bs) || (as == bs && au <= bu);
    endfunction

    // Add a time and an offset, carrying whole seconds out of the usec part.
    function automatic logic [51:0] time_add(input logic [31:0] as, input logic [19:0] au,
                                             input logic [31:0] bs, input logic [19:0] bu);
        logic [20:0] u;
        logic [31:0] s;
        u = au + bu;
        s = as + bs;
        if (u >= 21'd1000000) begin
            u = u - 21'd1000000;
            s = s + 1;
        end
        return {s, u[19:0]};
    endfunction

    // Difference a - b, borrowing a second when the usec part underflows.
    function automatic logic [51:0] time_sub(input logic [31:0] as, input logic [19:0] au,
                                             input logic [31:0] bs, input logic [19:0] bu);
        logic [31:0] s;
        logic [20:0] u;
        s = as - bs;
        if (au >= bu) begin
            u = au - bu;
        end else begin
            u = au + 21'd1000000 - bu;
            s = s - 1;
        end
        return {s, u[19:0]};
    endfunction

    task automatic table_insert(input entry_t e);
        int pos;
        pos = 0;
        if (n_timers >= SLOTS) return;
        // equal expiry goes behind existing timers
        while (pos < n_timers && not_later(tbl[pos].exp_sec, tbl[pos].exp_usec,
                                           e.exp_sec, e.exp_usec))
            pos++;
        for (int i = n_timers; i > pos; i--) tbl[i] = tbl[i-1];
        tbl[pos] = e;
        n_timers++;
    endtask

    task automatic table_remove(input int pos);
        for (int i = pos; i + 1 < n_timers; i++) tbl[i] = tbl[i+1];
        n_timers--;
    endtask

    task automatic predict_timer_op(input timer_op_t op);
        logic [19:0] nu, ivu, pru;
        logic [1:0]  st;
        logic [31:0] rid;
        logic [51:0] t;
        entry_t      e;
        result_t     r;
        int          fired;
        bit          found;
        int          i;
        nu = clamp_usec(op.now_u);
        ivu = clamp_usec(op.iv_u);
        pru = clamp_usec(op.pr_u);
        st = ST_OK;
        rid = '0;
        fired = 0;
        case (op.func)
            FUNC_ADD: begin
                if (n_timers >= SLOTS) begin
                    st = ST_FULL;
                end else begin
                    t = time_add(op.now_s, nu, op.iv_s, ivu);
                    if (id_next == 0) id_next = 1;
                    rid = id_next;
                    id_next++;
                    e = '{exp_sec: t[51:20], exp_usec: t[19:0], per_sec: op.pr_s,
                          per_usec: pru, owner: op.svc, id: rid};
                    table_insert(e);
                end
            end
            FUNC_DEL_ID: begin
                st = ST_INVALID;
                found = 0;
                for (i = 0; i < n_timers && !found; i++) begin
                    if (tbl[i].id == op.tid) begin
                        table_remove(i);
                        st = ST_OK;
                        found = 1;
                    end
                end
            end
            FUNC_DEL_SVC: begin
                i = 0;
                while (i < n_timers) begin
                    if (tbl[i].owner == op.svc) table_remove(i);
                    else i++;
                end
            end
            FUNC_CLEAR: n_timers = 0;
            FUNC_RST_MAX: begin
                late_s = '0;
                late_u = '0;
            end
            default: ;
        endcase
        while (fired < FIRE_CAP && n_timers > 0 &&
               not_later(tbl[0].exp_sec, tbl[0].exp_usec, op.now_s, nu)) begin
            e = tbl[0];
            t = time_sub(op.now_s, nu, e.exp_sec, e.exp_usec);
            if (t[51:20] > late_s || (t[51:20] == late_s && t[19:0] > late_u)) begin
                late_s = t[51:20];
                late_u = t[19:0];
            end
            table_remove(0);
            if (e.per_sec != 0 || e.per_usec != 0) begin
                t = time_add(e.exp_sec, e.exp_usec, e.per_sec, e.per_usec);
                e.exp_sec = t[51:20];
                e.exp_usec = t[19:0];
                table_insert(e);
            end
            r = '{kind: 1'b1, status: ST_OK, tid: e.id, svc: e.owner, dsec: '0, dusec: '0,
                  armed: (n_timers > 0), msec: late_s, musec: late_u, last: 1'b0};
            expect_q.push_back(r);
            fired++;
        end
        t = '0;
        if (n_timers > 0 && !not_later(tbl[0].exp_sec, tbl[0].exp_usec, op.now_s, nu))
            t = time_sub(tbl[0].exp_sec, tbl[0].exp_usec, op.now_s, nu);
        r = '{kind: 1'b0, status: st, tid: rid, svc: '0, dsec: t[51:20], dusec: t[19:0],
              armed: (n_timers > 0), msec: late_s, musec: late_u, last: 1'b1};
        expect_q.push_back(r);
    endtask

    function automatic bit field_ok(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
        if (want === got) return 1;
        if (mismatches < 10)
            $display("mismatch %s: expected %h, got %h", name, want, got);
        return 0;
    endfunction

    // accept input words and check result words at the rising edge
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        bit      ok;
        word_taken = aresetn && s_axis_tvalid && s_axis_tready;
        if (word_taken) predict_timer_op(cur_op);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{kind: m_axis_tuser, status: m_axis_tdata[1:0], tid: m_axis_tdata[33:2],
                    svc: m_axis_tdata[49:34], dsec: m_axis_tdata[81:50],
                    dusec: m_axis_tdata[101:82], armed: m_axis_tdata[102],
                    msec: m_axis_tdata[134:103], musec: m_axis_tdata[154:135],
                    last: m_axis_tlast};
            if (expect_q.size() == 0) begin
                if (mismatches < 10) $display("unexpected result word: %p", got);
                mismatches++;
            end else begin
                want = expect_q.pop_front();
                ok = field_ok("kind", want.kind, got.kind);
                ok &= field_ok("status", want.status, got.status);
                ok &= field_ok("timer_id", want.tid, got.tid);
                ok &= field_ok("service_id", want.svc, got.svc);
                ok &= field_ok("next_delay_sec", want.dsec, got.dsec);
                ok &= field_ok("next_delay_usec", want.dusec, got.dusec);
                ok &= field_ok("armed", want.armed, got.armed);
                ok &= field_ok("max_delay_sec", want.msec, got.msec);
                ok &= field_ok("max_delay_usec", want.musec, got.musec);
                ok &= field_ok("last", want.last, got.last);
                if (!ok) mismatches++;
            end
        end
    end

    // drive at the falling edge; idling depends on how far the run has come
    always @(negedge aclk) begin
        bit src_idle;
        bit snk_stall;
        src_idle = 0;
        snk_stall = 0;
        if (ops_sent >= 60 && ops_sent < 110) src_idle = ($urandom_range(0, 99) < 52);
        else if (ops_sent >= 160) src_idle = ($urandom_range(0, 99) < 12);
        if (ops_sent >= 110 && ops_sent < 160) snk_stall = ($urandom_range(0, 99) < 52);
        else if (ops_sent >= 160) snk_stall = ($urandom_range(0, 99) < 12);
        if (aresetn) begin
            m_axis_tready <= !snk_stall;
            if (!s_axis_tvalid || word_taken) begin
                if (op_q.size() > 0 && !src_idle &&
                    !(op_q[0].drain && expect_q.size() > 0)) begin
                    cur_op = op_q.pop_front();
                    ops_sent++;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {1'b0, cur_op.tid, cur_op.svc, cur_op.pr_u, cur_op.pr_s,
                                     cur_op.iv_u, cur_op.iv_s, cur_op.now_u, cur_op.now_s,
                                     cur_op.func};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic push_op(input logic [2:0] f, input logic [31:0] ns, input logic [19:0] nu,
                           input logic [31:0] is, input logic [19:0] iu,
                           input logic [31:0] ps, input logic [19:0] pu,
                           input logic [15:0] svc, input logic [31:0] tid);
        timer_op_t op;
        op = '{func: f, now_s: ns, now_u: nu, iv_s: is, iv_u: iu, pr_s: ps, pr_u: pu,
               svc: svc, tid: tid, drain: 0};
        op_q.push_back(op);
    endtask

    function automatic logic [19:0] rand_usec();
        return ($urandom_range(0, 19) == 0) ? 20'($urandom) : 20'($urandom_range(0, 999999));
    endfunction

    initial begin
        logic [31:0] base_s;
        logic [19:0] base_u;
        logic [51:0] t;
        int          r;
        int          adds;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        ops_sent = 0;
        word_taken = 0;
        n_timers = 0;
        id_next = 1;
        late_s = '0;
        late_u = '0;

        // directed: immediate fire, saturated usec, equal expiry, fire cap, deletes
        push_op(FUNC_ADD, 0, 0, 0, 0, 0, 0, 16'h0001, 0);
        push_op(FUNC_ADD, 10, 20'hFFFFF, 0, 20'hFFFFF, 0, 0, 16'hFFFF, 0);
        push_op(FUNC_ADD, 10, 5, 1, 0, 0, 0, 16'h0002, 0);
        push_op(FUNC_ADD, 10, 5, 1, 0, 0, 0, 16'h0003, 0);
        push_op(FUNC_CHECK, 11, 5, 0, 0, 0, 0, 0, 0);
        push_op(FUNC_ADD, 12, 0, 0, 1, 0, 1, 16'h0004, 0);
        push_op(FUNC_CHECK, 20, 0, 0, 0, 0, 0, 0, 0);
        push_op(3'd6, 20, 0, 0, 0, 0, 0, 0, 0);
        push_op(FUNC_DEL_ID, 20, 0, 0, 0, 0, 0, 0, 0);
        push_op(FUNC_DEL_ID, 20, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        push_op(FUNC_DEL_ID, 20, 0, 0, 0, 0, 0, 0, 32'd6);
        push_op(FUNC_ADD, 20, 0, 5, 999999, 32'hFFFF_FFFF, 999999, 16'h0007, 0);
        push_op(FUNC_ADD, 20, 0, 6, 0, 0, 0, 16'h0007, 0);
        push_op(FUNC_DEL_SVC, 20, 0, 0, 0, 0, 0, 16'h1234, 0);
        push_op(FUNC_DEL_SVC, 20, 0, 0, 0, 0, 0, 16'h0007, 0);
        push_op(FUNC_RST_MAX, 20, 0, 0, 0, 0, 0, 0, 0);
        push_op(FUNC_ADD, 32'hFFFF_FFFF, 999999, 32'hFFFF_FFFF, 999999, 0, 0, 16'h0008, 0);
        push_op(FUNC_ADD, 30, 0, 1, 0, 0, 0, 16'h0009, 0);
        push_op(FUNC_CLEAR, 30, 0, 0, 0, 0, 0, 0, 0);
        push_op(3'd7, 30, 0, 0, 0, 0, 0, 0, 0);
        // fill the table past its size
        for (int i = 0; i < SLOTS + 2; i++)
            push_op(FUNC_ADD, 30, 0, 100 + i, 20'($urandom_range(0, 999999)), 0, 0,
                    16'(i % 3), 0);
        push_op(FUNC_CLEAR, 30, 0, 0, 0, 0, 0, 0, 0);

        base_s = 40;
        base_u = 0;
        adds = 25 + SLOTS;
        for (int i = 0; i < 155; i++) begin
            t = time_add(base_s, base_u, 0, 20'($urandom_range(0, 400000)));
            base_s = t[51:20];
            base_u = t[19:0];
            r = $urandom_range(0, 99);
            if (r < 45) begin
                push_op(FUNC_ADD, base_s, rand_usec(), $urandom_range(0, 2), rand_usec(),
                        ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, 2),
                        ($urandom_range(0, 9) < 7) ? 20'd0 : rand_usec(),
                        16'($urandom_range(0, 3)), 0);
                adds++;
            end else if (r < 60) begin
                push_op(FUNC_CHECK, base_s, base_u, 0, 0, 0, 0, 0, 0);
            end else if (r < 72) begin
                push_op(FUNC_DEL_ID, base_s, base_u, 0, 0, 0, 0, 0,
                        $urandom_range(1, adds + 2));
            end else if (r < 80) begin
                push_op(FUNC_DEL_SVC, base_s, base_u, 0, 0, 0, 0,
                        16'($urandom_range(0, 4)), 0);
            end else if (r < 83) begin
                push_op(FUNC_CLEAR, base_s, base_u, 0, 0, 0, 0, 0, 0);
            end else if (r < 87) begin
                push_op(FUNC_RST_MAX, base_s, base_u, 0, 0, 0, 0, 0, 0);
            end else if (r < 91) begin
                push_op(3'($urandom_range(6, 7)), base_s, base_u, 0, 0, 0, 0, 0, 0);
            end else begin
                // noise: every field random, base time untouched
                push_op(3'($urandom_range(0, 7)), $urandom, 20'($urandom), $urandom,
                        20'($urandom), $urandom, 20'($urandom), 16'($urandom), $urandom);
            end
            if (i == 100) op_q[op_q.size()-1].drain = 1;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (op_q.size() > 0 || s_axis_tvalid) @(posedge aclk);
        while (expect_q.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && expect_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/stq_pkg.sv
hw/rtl/stq_time_unit.sv
hw/rtl/sorted_timer_queue.sv
dv/sorted_timer_queue_test.sv
